### rtl/dcr_pkg.sv
// Shared types, constants and encode helpers for the directional cell rule unit.
// No dependencies; used by every module under rtl/.
package dcr_pkg;

	localparam int unsigned StateW   = 8;
	localparam int unsigned CountW   = 9;
	localparam int unsigned TcW      = 7;
	localparam int unsigned TurnBits = 51;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned Dirs     = 4;

	typedef logic [StateW-1:0] state_t;
	typedef logic [Dirs-1:0][StateW-1:0] nbr_t;

	typedef enum logic [1:0] {
		ModeTurmite  = 2'd0,
		ModeSandpile = 2'd1,
		ModeHpp      = 2'd2,
		ModePass     = 2'd3
	} mode_t;

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] RegRuleMode   = 2'd0;
	localparam logic [CfgIdxW-1:0] RegStateCount = 2'd1;
	localparam logic [CfgIdxW-1:0] RegTurnMask   = 2'd2;

	localparam mode_t               ModeReset  = ModeHpp;
	localparam logic [CountW-1:0]   CountReset = 9'd16;
	localparam logic [TcW-1:0]      TcReset    = 7'd3;

	// count / 5 as (count * 205) >> 10, exact for counts below 1024
	localparam logic [16:0] TcMul   = 17'd205;
	localparam int unsigned TcShift = 10;

	localparam state_t SandHeights = 8'd8;
	localparam state_t HppPairA    = 8'h05;
	localparam state_t HppPairB    = 8'h0A;

	typedef struct packed {
		mode_t                mode;
		logic [CountW-1:0]    count;
		logic [TcW-1:0]       tc;
		logic [TurnBits-1:0]  turn_mask;
	} cfg_t;

	typedef struct packed {
		state_t                       centre;
		logic                         cell_lt_sc;
		logic                         cell_lt_tc;
		nbr_t                         nb;
		logic [Dirs-1:0]              nb_lt_sc;
		logic [Dirs-1:0]              nb_ge_tc;
		logic [Dirs-1:0][StateW-1:0]  nb_code;
	} s1_t;

	typedef struct packed {
		state_t           centre;
		logic             cell_lt_sc;
		logic             cell_lt_tc;
		logic             cell_ge_sand;
		logic [Dirs-1:0]  hits;
		logic [TcW-1:0]   agent_next;
		state_t           arrive_base;
		state_t           src_next;
		logic [2:0]       sand_h;
		logic [Dirs-1:0]  hpp_acc;
	} s2_t;

	// background-zero: 0 and 1 swap, all else unchanged (its own inverse)
	function automatic state_t bz_swap(input state_t s);
		state_t r;
		if (s == 8'd0)
			r = 8'd1;
		else if (s == 8'd1)
			r = 8'd0;
		else
			r = s;
		return r;
	endfunction

	function automatic logic [Dirs-1:0] hpp_collide(input state_t m);
		logic [Dirs-1:0] r;
		if (m == HppPairA)
			r = HppPairB[Dirs-1:0];
		else if (m == HppPairB)
			r = HppPairA[Dirs-1:0];
		else
			r = m[Dirs-1:0];
		return r;
	endfunction

endpackage

### rtl/directional_cell_rule_unit.sv
// An accepted input beat passes through three register stages on its way to out_valid.
// Throughput: one beat per cycle; an output stall holds each full stage in place.
// Config written on cfg_we applies to every beat accepted after the write edge.
// Reset (arst_n low, async): pipeline empty; HPP mode, 16 states, turn mask clear.
// Top level: config registers, stage valids and stall control. Uses dcr_pkg,
// dcr_front, dcr_rules and dcr_merge.
module directional_cell_rule_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dcr_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [dcr_pkg::TurnBits-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dcr_pkg::state_t                 cell_state,
	input  dcr_pkg::state_t                 neighbor_0,
	input  dcr_pkg::state_t                 neighbor_1,
	input  dcr_pkg::state_t                 neighbor_2,
	input  dcr_pkg::state_t                 neighbor_3,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dcr_pkg::state_t                 next_state
);

	dcr_pkg::mode_t                  rule_mode_q;
	logic [dcr_pkg::CountW-1:0]      state_count_q;
	logic [dcr_pkg::TurnBits-1:0]    turn_mask_q;
	logic [dcr_pkg::TcW-1:0]         tc_q;
	logic [16:0]                     tc_prod;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	dcr_pkg::cfg_t cfg;
	dcr_pkg::nbr_t nbr;
	dcr_pkg::s1_t  s1;
	dcr_pkg::s2_t  s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_mode_q   <= dcr_pkg::ModeReset;
			state_count_q <= dcr_pkg::CountReset;
			turn_mask_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dcr_pkg::RegRuleMode:   rule_mode_q   <= dcr_pkg::mode_t'(cfg_data[1:0]);
				dcr_pkg::RegStateCount: state_count_q <= cfg_data[dcr_pkg::CountW-1:0];
				dcr_pkg::RegTurnMask:   turn_mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// tape colour count = state_count / 5, taken from the write data
	assign tc_prod = {8'd0, cfg_data[dcr_pkg::CountW-1:0]} * dcr_pkg::TcMul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tc_q <= dcr_pkg::TcReset;
		else if (cfg_we && cfg_index == dcr_pkg::RegStateCount)
			tc_q <= tc_prod[dcr_pkg::TcShift +: dcr_pkg::TcW];
	end

	assign cfg.mode      = rule_mode_q;
	assign cfg.count     = state_count_q;
	assign cfg.tc        = tc_q;
	assign cfg.turn_mask = turn_mask_q;

	assign nbr[0] = neighbor_0;
	assign nbr[1] = neighbor_1;
	assign nbr[2] = neighbor_2;
	assign nbr[3] = neighbor_3;

	// a stage loads when it is empty or its contents move on
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;

	dcr_front u_front (
		.clk        (clk),
		.en         (en1 && in_valid),
		.cfg        (cfg),
		.cell_state (cell_state),
		.nbr        (nbr),
		.s1         (s1)
	);

	dcr_rules u_rules (
		.clk (clk),
		.en  (en2 && v_s1),
		.cfg (cfg),
		.s1  (s1),
		.s2  (s2)
	);

	dcr_merge u_merge (
		.clk        (clk),
		.en         (en3 && v_s2),
		.cfg        (cfg),
		.s2         (s2),
		.next_state (next_state)
	);

`ifndef SYNTHESIS
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while output side is free");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted beat did not reach the output after three cycles");

	a_tc_range: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(state_count_q) |->
			(10'(tc_q) * 10'd5 <= 10'(state_count_q)) &&
			(10'(state_count_q) < 10'(tc_q) * 10'd5 + 10'd5))
		else $error("tape colour count does not match state_count / 5");

	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en3) |=> v_s2 && v_s3)
		else $error("stage 2 beat lost during an output stall");
`endif

endmodule

### rtl/dcr_front.sv
// Stage 1: range checks of the cell and neighbours against the state count and
// tape colour count, and agent codes. Depends on dcr_pkg.
module dcr_front (
	input  logic            clk,
	input  logic            en,
	input  dcr_pkg::cfg_t   cfg,
	input  dcr_pkg::state_t cell_state,
	input  dcr_pkg::nbr_t   nbr,
	output dcr_pkg::s1_t    s1
);

	dcr_pkg::s1_t nxt;
	dcr_pkg::s1_t data_s1;

	always_comb begin
		nxt            = '0;
		nxt.centre     = cell_state;
		nxt.cell_lt_sc = {1'b0, cell_state} < cfg.count;
		nxt.cell_lt_tc = cell_state < {1'b0, cfg.tc};
		nxt.nb         = nbr;
		for (int i = 0; i < dcr_pkg::Dirs; i++) begin
			nxt.nb_lt_sc[i] = {1'b0, nbr[i]} < cfg.count;
			nxt.nb_ge_tc[i] = nbr[i] >= {1'b0, cfg.tc};
			nxt.nb_code[i]  = nbr[i] - {1'b0, cfg.tc};
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign s1 = data_s1;

endmodule

### rtl/dcr_rules.sv
// Stage 2: per-mode evaluation - turmite hits and tape advance, sandpile
// heights and source phase, HPP collision and gather. Depends on dcr_pkg.
module dcr_rules (
	input  logic          clk,
	input  logic          en,
	input  dcr_pkg::cfg_t cfg,
	input  dcr_pkg::s1_t  s1,
	output dcr_pkg::s2_t  s2
);

	dcr_pkg::s2_t nxt;
	dcr_pkg::s2_t data_s2;

	always_comb begin
		logic [63:0]               mask_ext;
		logic [5:0]                color;
		logic                      right;
		logic [1:0]                nd;
		dcr_pkg::state_t           code_c;
		dcr_pkg::state_t           dec;
		logic [dcr_pkg::TcW-1:0]   adv;
		logic [2:0]                cnt;
		logic [dcr_pkg::CountW-1:0] x9;
		logic [dcr_pkg::CountW-1:0] period;
		logic [dcr_pkg::Dirs-1:0]  m;

		// colours 51 and up read as a left turn
		mask_ext = {{(64 - dcr_pkg::TurnBits){1'b0}}, cfg.turn_mask};

		nxt              = '0;
		nxt.centre       = s1.centre;
		nxt.cell_lt_sc   = s1.cell_lt_sc;
		nxt.cell_lt_tc   = s1.cell_lt_tc;
		nxt.cell_ge_sand = s1.centre >= dcr_pkg::SandHeights;

		// turmite: which neighbours turn into this cell
		for (int i = 0; i < dcr_pkg::Dirs; i++) begin
			color        = s1.nb_code[i][7:2];
			right        = mask_ext[color];
			nd           = s1.nb_code[i][1:0] + (right ? 2'd1 : 2'd3);
			nxt.hits[i]  = s1.nb_ge_tc[i] && s1.nb_lt_sc[i] && (nd == 2'(i + 2));
		end

		// turmite: agent leaves, tape colour + 1 mod tc (at most tc + 1, two subtracts)
		code_c = s1.centre - {1'b0, cfg.tc};
		adv    = {1'b0, code_c[7:2]} + 7'd1;
		if (adv >= cfg.tc)
			adv = adv - cfg.tc;
		if (adv >= cfg.tc)
			adv = adv - cfg.tc;
		nxt.agent_next = adv;

		dec             = dcr_pkg::bz_swap(s1.centre);
		nxt.arrive_base = {1'b0, cfg.tc} + {dec[5:0], 2'b00};

		// sandpile: topple, then count grains arriving
		cnt = 3'd0;
		for (int i = 0; i < dcr_pkg::Dirs; i++) begin
			if (s1.nb[i] == dcr_pkg::SandHeights || s1.nb[i][7:2] == 6'd1)
				cnt = cnt + 3'd1;
		end
		nxt.sand_h = {1'b0, dec[1:0]} + cnt;

		x9     = {1'b0, s1.centre} - 9'd7;
		period = cfg.count - 9'd8;
		nxt.src_next = (x9 == period) ? dcr_pkg::SandHeights
			: 8'(x9 + {1'b0, dcr_pkg::SandHeights});

		// HPP: collide each neighbour, keep the bit heading here
		for (int i = 0; i < dcr_pkg::Dirs; i++) begin
			m = dcr_pkg::hpp_collide(dcr_pkg::bz_swap(s1.nb[i]));
			nxt.hpp_acc[2'(i + 2)] = s1.nb_lt_sc[i] & m[2'(i + 2)];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s2 <= nxt;
	end

	assign s2 = data_s2;

endmodule

### rtl/dcr_merge.sv
// Stage 3: mode select, background-zero encode and output register.
// Depends on dcr_pkg.
module dcr_merge (
	input  logic            clk,
	input  logic            en,
	input  dcr_pkg::cfg_t   cfg,
	input  dcr_pkg::s2_t    s2,
	output dcr_pkg::state_t next_state
);

	dcr_pkg::state_t res;
	dcr_pkg::state_t data_s3;

	always_comb begin
		logic [1:0] dir;
		logic       arrive;

		dir    = 2'd0;
		arrive = 1'b1;
		// the single hitting neighbour fixes the heading
		case (s2.hits)
			4'b0001: dir = 2'd2;
			4'b0010: dir = 2'd3;
			4'b0100: dir = 2'd0;
			4'b1000: dir = 2'd1;
			default: arrive = 1'b0;
		endcase

		case (cfg.mode)
			dcr_pkg::ModeTurmite: begin
				if (!s2.cell_lt_sc || cfg.tc == '0)
					res = 8'd1;
				else if (!s2.cell_lt_tc)
					res = dcr_pkg::bz_swap({1'b0, s2.agent_next});
				else if (arrive)
					res = s2.arrive_base + {6'd0, dir};
				else
					res = s2.centre;
			end
			dcr_pkg::ModeSandpile: begin
				if (!s2.cell_lt_sc)
					res = 8'd1;
				else if (s2.cell_ge_sand)
					res = s2.src_next;
				else
					res = dcr_pkg::bz_swap({5'd0, s2.sand_h});
			end
			dcr_pkg::ModeHpp: res = dcr_pkg::bz_swap({4'd0, s2.hpp_acc});
			default: res = s2.centre;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s3 <= res;
	end

	assign next_state = data_s3;

endmodule

### sim/tb_top.sv
// Self-checking bench for directional_cell_rule_unit: turmite, sandpile, HPP and pass modes.
// Input and output beats carry random gaps and stalls; each output is checked in order.
// Depends on rtl/dcr_pkg.sv and rtl/directional_cell_rule_unit.sv.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CycleLimit = 200000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [dcr_pkg::CfgIdxW-1:0]  cfg_index;
	logic [dcr_pkg::TurnBits-1:0] cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	dcr_pkg::state_t              cell_state;
	dcr_pkg::state_t              neighbor_0;
	dcr_pkg::state_t              neighbor_1;
	dcr_pkg::state_t              neighbor_2;
	dcr_pkg::state_t              neighbor_3;
	logic                         out_valid;
	logic                         out_ready;
	dcr_pkg::state_t              next_state;

	// shadow of the block's registers, reset values first
	dcr_pkg::mode_t               cur_mode  = dcr_pkg::ModeHpp;
	logic [dcr_pkg::CountW-1:0]   cur_count = 9'd16;
	logic [dcr_pkg::TurnBits-1:0] cur_mask  = '0;

	dcr_pkg::state_t next_state_q[$];
	dcr_pkg::state_t want;
	int              failures    = 0;
	int unsigned     cycle_count = 0;
	bit              tx_quiet    = 1'b0;
	bit              rx_quiet    = 1'b0;
	int unsigned     hold_len    = 0;

	directional_cell_rule_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_state (cell_state),
		.neighbor_0 (neighbor_0),
		.neighbor_1 (neighbor_1),
		.neighbor_2 (neighbor_2),
		.neighbor_3 (neighbor_3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_state (next_state)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned swap_zero_one(int unsigned v);
		if (v == 0)
			return 1;
		else if (v == 1)
			return 0;
		return v;
	endfunction

	function automatic dcr_pkg::state_t rule_next_state(dcr_pkg::mode_t mode,
			logic [dcr_pkg::CountW-1:0] count, logic [dcr_pkg::TurnBits-1:0] mask,
			dcr_pkg::state_t centre, dcr_pkg::nbr_t nb);
		int unsigned n, c, tc, r, s, code, colour, nd, dir, hits, h, acc, bitpos, m, i;
		logic right;
		n  = count;
		c  = centre;
		tc = n / 5;
		r  = c;
		case (mode)
			dcr_pkg::ModeTurmite: begin
				if (c >= n || tc == 0) begin
					r = 1;
				end else if (c >= tc) begin
					r = swap_zero_one(((c - tc) / 4 + 1) % tc);
				end else begin
					hits = 0;
					dir  = 0;
					for (i = 0; i < 4; i++) begin
						s = nb[i];
						if (s >= tc && s < n) begin
							code   = s - tc;
							colour = code / 4;
							right  = (colour < dcr_pkg::TurnBits) ? mask[colour] : 1'b0;
							nd     = (code % 4 + (right ? 1 : 3)) % 4;
							if (nd == (i + 2) % 4) begin
								hits++;
								dir = nd;
							end
						end
					end
					if (hits == 1)
						r = tc + swap_zero_one(c) * 4 + dir;
				end
			end
			dcr_pkg::ModeSandpile: begin
				if (c >= n) begin
					r = 1;
				end else if (c >= dcr_pkg::SandHeights) begin
					r = dcr_pkg::SandHeights
						+ (c - dcr_pkg::SandHeights + 1) % (n - dcr_pkg::SandHeights);
				end else begin
					h = swap_zero_one(c);
					if (h >= 4)
						h -= 4;
					for (i = 0; i < 4; i++) begin
						s = nb[i];
						if (s == dcr_pkg::SandHeights
								|| (s < dcr_pkg::SandHeights && swap_zero_one(s) >= 4))
							h++;
					end
					r = swap_zero_one(h);
				end
			end
			dcr_pkg::ModeHpp: begin
				acc = 0;
				for (i = 0; i < 4; i++) begin
					if (nb[i] < n) begin
						bitpos = (i + 2) % 4;
						m = swap_zero_one(nb[i]);
						if (m == dcr_pkg::HppPairA)
							m = dcr_pkg::HppPairB;
						else if (m == dcr_pkg::HppPairB)
							m = dcr_pkg::HppPairA;
						if (((m >> bitpos) & 1) != 0)
							acc |= 1 << bitpos;
					end
				end
				r = swap_zero_one(acc);
			end
			default: r = c;
		endcase
		return dcr_pkg::state_t'(r % 256);
	endfunction

	// expected results are queued on input acceptance, then matched in order
	always @(posedge clk) begin
		if (in_valid && in_ready)
			next_state_q.push_back(rule_next_state(cur_mode, cur_count, cur_mask, cell_state,
				{neighbor_3, neighbor_2, neighbor_1, neighbor_0}));
		if (out_valid && out_ready) begin
			if (next_state_q.size() == 0) begin
				$error("next_state: expected none, actual %0d", next_state);
				failures++;
			end else begin
				want = next_state_q.pop_front();
				if (next_state !== want) begin
					$error("next_state: expected %0d, actual %0d", want, next_state);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("directional_cell_rule_unit regression: fail");
			$finish;
		end
	end

	// receiver: random stall per beat, or one long hold-off on request
	initial begin : rx_side
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				stall    = hold_len;
				hold_len = 0;
			end else begin
				stall = rx_quiet ? 0 : $urandom_range(6, 0);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [dcr_pkg::TurnBits-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[dcr_pkg::TurnBits-1:0];
	endfunction

	task automatic send_beat(dcr_pkg::state_t centre, dcr_pkg::state_t n0,
			dcr_pkg::state_t n1, dcr_pkg::state_t n2, dcr_pkg::state_t n3);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(6, 0);
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		cell_state <= centre;
		neighbor_0 <= n0;
		neighbor_1 <= n1;
		neighbor_2 <= n2;
		neighbor_3 <= n3;
		do @(posedge clk); while (!in_ready);
	endtask

	// registers change only with the pipe empty; the tape count loads at the same write edge as the state count
	task automatic write_reg(logic [dcr_pkg::CfgIdxW-1:0] idx,
			logic [dcr_pkg::TurnBits-1:0] data);
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (next_state_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			dcr_pkg::RegRuleMode:   cur_mode  = dcr_pkg::mode_t'(data[1:0]);
			dcr_pkg::RegStateCount: cur_count = data[dcr_pkg::CountW-1:0];
			dcr_pkg::RegTurnMask:   cur_mask  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// unused upper data bits are randomised: the block must drop them
	task automatic set_config(dcr_pkg::mode_t mode, int unsigned count,
			logic [dcr_pkg::TurnBits-1:0] mask);
		logic [dcr_pkg::TurnBits-1:0] data;
		data       = rand_word();
		data[1:0]  = mode;
		write_reg(dcr_pkg::RegRuleMode, data);
		data       = rand_word();
		data[dcr_pkg::CountW-1:0] = count[dcr_pkg::CountW-1:0];
		write_reg(dcr_pkg::RegStateCount, data);
		write_reg(dcr_pkg::RegTurnMask, mask);
	endtask

	// agent in direction dir whose turned heading points at the centre cell
	function automatic dcr_pkg::state_t agent_toward(int unsigned dir);
		int unsigned tc, top, s, colour, nd, h;
		logic right;
		tc     = cur_count / 5;
		top    = (cur_count > 256) ? 255 : cur_count - 1;
		s      = $urandom_range(top, tc);
		colour = (s - tc) / 4;
		right  = (colour < dcr_pkg::TurnBits) ? cur_mask[colour] : 1'b0;
		nd     = (dir + 2) % 4;
		h      = right ? (nd + 3) % 4 : (nd + 1) % 4;
		s      = tc + 4 * colour + h;
		if (s > top)
			s = tc;
		return dcr_pkg::state_t'(s);
	endfunction

	task automatic send_turmite_mix(int n);
		int unsigned tc, top, k, i;
		dcr_pkg::state_t centre;
		dcr_pkg::nbr_t   nb;
		tc  = cur_count / 5;
		top = (cur_count > 256) ? 255 : cur_count - 1;
		repeat (n) begin
			k = $urandom_range(9, 0);
			if (k < 4)
				centre = dcr_pkg::state_t'($urandom_range(tc - 1, 0));
			else if (k < 7)
				centre = dcr_pkg::state_t'($urandom_range(top, tc));
			else
				centre = dcr_pkg::state_t'($urandom);
			for (i = 0; i < 4; i++) begin
				k = $urandom_range(9, 0);
				if (k < 4)
					nb[i] = agent_toward(i);
				else if (k < 6)
					nb[i] = dcr_pkg::state_t'($urandom_range(top, tc));
				else if (k < 8)
					nb[i] = dcr_pkg::state_t'($urandom_range(tc - 1, 0));
				else
					nb[i] = dcr_pkg::state_t'($urandom);
			end
			send_beat(centre, nb[0], nb[1], nb[2], nb[3]);
		end
	endtask

	task automatic send_sandpile_mix(int n);
		int unsigned hi, k, i;
		dcr_pkg::state_t centre;
		dcr_pkg::nbr_t   nb;
		hi = (cur_count + 1 > 255) ? 255 : cur_count + 1;
		if (hi < dcr_pkg::SandHeights)
			hi = dcr_pkg::SandHeights;
		repeat (n) begin
			k = $urandom_range(9, 0);
			if (k < 5)
				centre = dcr_pkg::state_t'($urandom_range(7, 0));
			else if (k < 8)
				centre = dcr_pkg::state_t'($urandom_range(hi, dcr_pkg::SandHeights));
			else
				centre = dcr_pkg::state_t'($urandom);
			for (i = 0; i < 4; i++) begin
				k = $urandom_range(9, 0);
				if (k < 6)
					nb[i] = dcr_pkg::state_t'($urandom_range(7, 0));
				else if (k < 8)
					nb[i] = dcr_pkg::SandHeights;
				else
					nb[i] = dcr_pkg::state_t'($urandom);
			end
			send_beat(centre, nb[0], nb[1], nb[2], nb[3]);
		end
	endtask

	task automatic send_hpp_mix(int n);
		int unsigned k, i;
		dcr_pkg::nbr_t nb;
		repeat (n) begin
			for (i = 0; i < 4; i++) begin
				k = $urandom_range(9, 0);
				if (k < 3)
					nb[i] = k[0] ? dcr_pkg::HppPairA : dcr_pkg::HppPairB;
				else if (k < 7)
					nb[i] = dcr_pkg::state_t'($urandom_range(15, 0));
				else
					nb[i] = dcr_pkg::state_t'($urandom);
			end
			send_beat(dcr_pkg::state_t'($urandom), nb[0], nb[1], nb[2], nb[3]);
		end
	endtask

	task automatic send_noise(int n);
		repeat (n)
			send_beat(dcr_pkg::state_t'($urandom), dcr_pkg::state_t'($urandom),
				dcr_pkg::state_t'($urandom), dcr_pkg::state_t'($urandom),
				dcr_pkg::state_t'($urandom));
	endtask

	// reset settings: HPP, 16 states
	task automatic test_hpp_directed();
		send_beat(8'd0, dcr_pkg::HppPairA, dcr_pkg::HppPairA, dcr_pkg::HppPairA,
			dcr_pkg::HppPairA);
		send_beat(8'd255, dcr_pkg::HppPairB, dcr_pkg::HppPairB, dcr_pkg::HppPairB,
			dcr_pkg::HppPairB);
		send_beat(8'd7, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_beat(8'd1, 8'd15, 8'd15, 8'd15, 8'd15);
	endtask

	task automatic test_turmite_directed();
		set_config(dcr_pkg::ModeTurmite, 25, 51'h5);
		send_beat(8'd23, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(8'd6, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(8'd2, agent_toward(0), 8'd0, 8'd0, 8'd3);
		send_beat(8'd0, agent_toward(0), agent_toward(1), 8'd0, 8'd0);
		send_beat(8'd30, 8'd30, 8'd24, 8'd0, 8'd0);
		// no tape colours at all
		set_config(dcr_pkg::ModeTurmite, 4, '0);
		send_beat(8'd0, 8'd4, 8'd3, 8'd2, 8'd1);
		// colour 51 lies past the mask and must turn left
		set_config(dcr_pkg::ModeTurmite, 256, {dcr_pkg::TurnBits{1'b1}});
		send_beat(8'd50, 8'd0, 8'd255, 8'd0, 8'd0);
		// arrival state wraps past 8 bits
		set_config(dcr_pkg::ModeTurmite, 511, {dcr_pkg::TurnBits{1'b1}});
		send_beat(8'd101, 8'd0, 8'd0, agent_toward(2), 8'd0);
	endtask

	task automatic test_sandpile_directed();
		set_config(dcr_pkg::ModeSandpile, 12, rand_word());
		send_beat(8'd5, 8'd8, 8'd8, 8'd4, 8'd0);
		send_beat(8'd11, 8'd0, 8'd0, 8'd0, 8'd0);
		send_beat(8'd9, 8'd8, 8'd8, 8'd8, 8'd8);
		send_beat(8'd12, 8'd8, 8'd8, 8'd8, 8'd8);
		send_beat(8'd0, 8'd1, 8'd7, 8'd200, 8'd9);
		set_config(dcr_pkg::ModeSandpile, 511, rand_word());
		send_beat(8'd255, 8'd8, 8'd6, 8'd8, 8'd5);
	endtask

	task automatic test_pass_mode();
		set_config(dcr_pkg::ModePass, 300, rand_word());
		send_beat(8'hA5, 8'h5A, 8'd255, 8'd0, 8'd1);
		send_beat(8'h5A, 8'hA5, 8'd0, 8'd255, 8'd8);
		send_noise(50);
	endtask

	task automatic test_turmite_random();
		set_config(dcr_pkg::ModeTurmite, 25, rand_word());
		send_turmite_mix(100);
		set_config(dcr_pkg::ModeTurmite, $urandom_range(120, 5), rand_word());
		send_turmite_mix(100);
		set_config(dcr_pkg::ModeTurmite, 256, {dcr_pkg::TurnBits{1'b1}});
		send_turmite_mix(100);
		set_config(dcr_pkg::ModeTurmite, 511, '0);
		send_turmite_mix(100);
	endtask

	task automatic test_sandpile_random();
		set_config(dcr_pkg::ModeSandpile, 12, rand_word());
		send_sandpile_mix(75);
		set_config(dcr_pkg::ModeSandpile, $urandom_range(60, 9), rand_word());
		send_sandpile_mix(75);
		set_config(dcr_pkg::ModeSandpile, 256, rand_word());
		send_sandpile_mix(75);
		set_config(dcr_pkg::ModeSandpile, 8, rand_word());
		send_sandpile_mix(75);
	endtask

	task automatic test_hpp_random();
		set_config(dcr_pkg::ModeHpp, 16, rand_word());
		send_hpp_mix(75);
		set_config(dcr_pkg::ModeHpp, 1, rand_word());
		send_hpp_mix(75);
		set_config(dcr_pkg::ModeHpp, 256, rand_word());
		send_hpp_mix(75);
		set_config(dcr_pkg::ModeHpp, $urandom_range(20, 2), rand_word());
		send_hpp_mix(75);
	endtask

	task automatic test_config_sweep();
		repeat (5) begin
			set_config(dcr_pkg::mode_t'($urandom_range(3, 0)), $urandom_range(511, 1),
				rand_word());
			send_noise(24);
		end
	endtask

	// sender keeps offering while the receiver sits out a long stretch
	task automatic test_backpressure();
		set_config(dcr_pkg::ModeHpp, 16, rand_word());
		tx_quiet = 1'b1;
		hold_len = 48;
		send_hpp_mix(60);
		tx_quiet = 1'b0;
	endtask

	task automatic test_back_to_back();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		set_config(dcr_pkg::ModeSandpile, 20, rand_word());
		send_sandpile_mix(80);
		set_config(dcr_pkg::ModeTurmite, 60, rand_word());
		send_turmite_mix(80);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin : stimulus
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = dcr_pkg::RegRuleMode;
		cfg_data   = '0;
		in_valid   = 1'b0;
		cell_state = '0;
		neighbor_0 = '0;
		neighbor_1 = '0;
		neighbor_2 = '0;
		neighbor_3 = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_hpp_directed();
		test_turmite_directed();
		test_sandpile_directed();
		test_pass_mode();
		test_turmite_random();
		test_sandpile_random();
		test_hpp_random();
		test_config_sweep();
		test_backpressure();
		test_back_to_back();

		@(negedge clk);
		in_valid <= 1'b0;
		while (next_state_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("directional_cell_rule_unit regression: pass");
		else
			$display("directional_cell_rule_unit regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/dcr_pkg.sv
rtl/dcr_front.sv
rtl/dcr_rules.sv
rtl/dcr_merge.sv
rtl/directional_cell_rule_unit.sv
sim/tb_top.sv
